// File: design/mlhc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlhc_pkg
// Shared codes and field widths of the Laplacian / HC mesh smoother.
// ----------------------------------------------------------------------------
package mlhc_pkg;

  localparam int IDX_W      = 10;
  localparam int POS_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_RUN    = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_SAT   = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VCOUNT = 3'd0,
    CFG_PASSES = 3'd1,
    CFG_HC     = 3'd2,
    CFG_ALPHA  = 3'd3,
    CFG_BETA   = 3'd4
  } cfg_e;

endpackage
`default_nettype wire

// File: design/mesh_laplacian_hc_smoother.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mesh_laplacian_hc_smoother
// Umbrella smoothing of a loaded mesh with optional HC push-back.
// ----------------------------------------------------------------------------
// Commands are taken on start while busy is low: load vertex, append
// neighbour, run and read vertex. Every command answers with one result,
// shown for one cycle while result_valid_o is high; the receiver cannot stall
// it. Load answers from S_LOAD, append from S_APP_WR after a count read, read
// from S_RD_OUT after a memory read; the result is registered. A run is driven
// by a sequencer around vertex memories that each have one registered read
// port and one write port. Each axis of a vertex update is divided by a
// bit-serial rounding divider. HC adds a copy of the current positions, a
// sweep that forms the differences b and a push-back sweep over the vertices.
// After reset all MAX_VERTICES neighbour counts are cleared, one entry a
// cycle; busy stays high meanwhile. Configuration writes are taken at any
// time on the write port.
// ----------------------------------------------------------------------------
module mesh_laplacian_hc_smoother
  import mlhc_pkg::*;
#(
  parameter int MAX_VERTICES   = 1024,
  parameter int MAX_NEIGHBOURS = 16,
  parameter int COORD_WIDTH    = 32
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  wire  [1:0]                   command_i,
  input  wire  [IDX_W-1:0]             vertex_index_i,
  input  wire  [IDX_W-1:0]             neighbour_index_i,
  input  wire  signed [POS_W-1:0]      pos_x_i,
  input  wire  signed [POS_W-1:0]      pos_y_i,
  input  wire  signed [POS_W-1:0]      pos_z_i,
  output logic                         result_valid_o,
  output logic [IDX_W-1:0]             echo_index_o,
  output logic signed [POS_W-1:0]      out_x_o,
  output logic signed [POS_W-1:0]      out_y_o,
  output logic signed [POS_W-1:0]      out_z_o,
  output logic [1:0]                   status_o,
  input  wire                          cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]         cfg_index_i,
  input  wire  [CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int PW   = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int VAW  = $clog2(MAX_VERTICES);
  localparam int VCW  = $clog2(MAX_VERTICES + 1);
  localparam int NCW  = $clog2(MAX_NEIGHBOURS + 1);
  localparam int TAW  = $clog2(MAX_VERTICES * MAX_NEIGHBOURS);
  localparam int AW   = PW + NCW;
  localparam int HNW  = PW + NCW + 18;
  localparam int DENW = 16 + NCW;
  localparam int DCW  = $clog2(HNW + 1);
  localparam int CW   = POS_W + 2;

  localparam logic [4:0] S_CLEAR    = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_LOAD     = 5'd2;
  localparam logic [4:0] S_APP_RD   = 5'd3;
  localparam logic [4:0] S_APP_WR   = 5'd4;
  localparam logic [4:0] S_RD_ISS   = 5'd5;
  localparam logic [4:0] S_RD_OUT   = 5'd6;
  localparam logic [4:0] S_CP_OCP   = 5'd7;
  localparam logic [4:0] S_PASS_CHK = 5'd8;
  localparam logic [4:0] S_CP_CP    = 5'd9;
  localparam logic [4:0] S_V_START  = 5'd10;
  localparam logic [4:0] S_V_CHK    = 5'd11;
  localparam logic [4:0] S_T_RD     = 5'd12;
  localparam logic [4:0] S_N_RD     = 5'd13;
  localparam logic [4:0] S_ACC      = 5'd14;
  localparam logic [4:0] S_SELF_RD  = 5'd15;
  localparam logic [4:0] S_AX_SET   = 5'd16;
  localparam logic [4:0] S_HM2      = 5'd17;
  localparam logic [4:0] S_HM3      = 5'd18;
  localparam logic [4:0] S_DIV_GO   = 5'd19;
  localparam logic [4:0] S_DIV_RUN  = 5'd20;
  localparam logic [4:0] S_AX_END   = 5'd21;
  localparam logic [4:0] S_V_WR     = 5'd22;
  localparam logic [4:0] S_CP_CD    = 5'd23;
  localparam logic [4:0] S_B_START  = 5'd24;
  localparam logic [4:0] S_BM1      = 5'd25;
  localparam logic [4:0] S_BM2      = 5'd26;
  localparam logic [4:0] S_BM3      = 5'd27;
  localparam logic [4:0] S_B_WR     = 5'd28;
  localparam logic [4:0] S_FIN      = 5'd29;

  function automatic logic fits_pos(input logic signed [CW-1:0] x);
    logic [CW-PW:0] top;
    top = x[CW-1:PW-1];
    return (&top) | (~|top);
  endfunction

  function automatic logic [PW-1:0] clamp_pos(input logic signed [CW-1:0] x);
    if (fits_pos(x)) begin
      return x[PW-1:0];
    end else if (x[CW-1]) begin
      return {1'b1, {(PW-1){1'b0}}};
    end else begin
      return {1'b0, {(PW-1){1'b1}}};
    end
  endfunction

  // Memories.
  logic [3*PW-1:0]  orig_mem [MAX_VERTICES];
  logic [3*PW-1:0]  cur_mem  [MAX_VERTICES];
  logic [3*PW-1:0]  prev_mem [MAX_VERTICES];
  logic [3*PW-1:0]  diff_mem [MAX_VERTICES];
  logic [IDX_W-1:0] nbt_mem  [MAX_VERTICES*MAX_NEIGHBOURS];
  logic [NCW-1:0]   cnt_mem  [MAX_VERTICES];

  logic            o_re, o_we, c_re, c_we, p_re, p_we, d_re, d_we;
  logic            t_re, t_we, n_re, n_we;
  logic [VAW-1:0]  o_ra, o_wa, c_ra, c_wa, p_ra, p_wa, d_ra, d_wa, n_ra, n_wa;
  logic [TAW-1:0]  t_ra, t_wa;
  logic [3*PW-1:0] o_wd, c_wd, p_wd, d_wd;
  logic [IDX_W-1:0] t_wd;
  logic [NCW-1:0]  n_wd;
  logic [3*PW-1:0] o_rd_q, c_rd_q, p_rd_q, d_rd_q;
  logic [IDX_W-1:0] t_rd_q;
  logic [NCW-1:0]  n_rd_q;

  always_ff @(posedge clk_i) begin
    if (o_we) orig_mem[o_wa] <= o_wd;
    if (o_re) o_rd_q <= orig_mem[o_ra];
  end
  always_ff @(posedge clk_i) begin
    if (c_we) cur_mem[c_wa] <= c_wd;
    if (c_re) c_rd_q <= cur_mem[c_ra];
  end
  always_ff @(posedge clk_i) begin
    if (p_we) prev_mem[p_wa] <= p_wd;
    if (p_re) p_rd_q <= prev_mem[p_ra];
  end
  always_ff @(posedge clk_i) begin
    if (d_we) diff_mem[d_wa] <= d_wd;
    if (d_re) d_rd_q <= diff_mem[d_ra];
  end
  always_ff @(posedge clk_i) begin
    if (t_we) nbt_mem[t_wa] <= t_wd;
    if (t_re) t_rd_q <= nbt_mem[t_ra];
  end
  always_ff @(posedge clk_i) begin
    if (n_we) cnt_mem[n_wa] <= n_wd;
    if (n_re) n_rd_q <= cnt_mem[n_ra];
  end

  // Control registers.
  logic [4:0]     state_q, state_d;
  logic [VCW-1:0] sw_q, sw_d, v_q, v_d;
  logic           sw_pend_q, sw_pend_d;
  logic [NCW-1:0] k_q, k_d;
  logic [1:0]     axis_q, axis_d;
  logic [7:0]     pc_q, pc_d;
  logic           hc_ph_q, hc_ph_d;
  logic [DCW-1:0] dcnt_q, dcnt_d;
  logic           rv_q, rv_d;
  logic           sat_q, sat_d;
  logic [10:0]    vertex_count_q;
  logic [7:0]     pass_count_q;
  logic           hc_en_q;
  logic [16:0]    alpha_q, beta_q;

  // Datapath registers.
  logic [1:0]              cmd_q, cmd_d;
  logic [IDX_W-1:0]        vi_q, vi_d, ni_q, ni_d;
  logic signed [POS_W-1:0] pos_q [3];
  logic signed [POS_W-1:0] pos_d [3];
  logic [VAW-1:0]          sw_addr_q, sw_addr_d;
  logic [TAW-1:0]          base_q, base_d;
  logic [NCW-1:0]          c_q, c_d;
  logic signed [AW-1:0]    acc_q [3];
  logic signed [AW-1:0]    acc_d [3];
  logic [3*PW-1:0]         res_q, res_d;
  logic signed [PW+17:0]   p1_q, p1_d;
  logic signed [AW+17:0]   p2_q, p2_d;
  logic signed [HNW-1:0]   num_q, num_d;
  logic [DENW-1:0]         den_q, den_d;
  logic [HNW-1:0]          dvq_q, dvq_d;
  logic [DENW-1:0]         rem_q, rem_d;
  logic                    dneg_q, dneg_d;
  logic [IDX_W-1:0]        echo_q, echo_d;
  logic signed [POS_W-1:0] ox_q, ox_d, oy_q, oy_d, oz_q, oz_d;
  logic [1:0]              st_q, st_d;

  // Combinational helpers.
  logic                    accept;
  logic [VCW-1:0]          cnt_eff;
  logic                    vi_ok, ni_ok, nb_ok, v_done, sw_issue, sw_done;
  logic [VAW-1:0]          vi_a, v_a, nb_a;
  logic [16:0]             alpha_e, beta_e, om_alpha, om_beta;
  logic signed [PW-1:0]    o_ax, c_ax, p_ax, d_ax;
  logic signed [CW-1:0]    ld_ext [3];
  logic [3*PW-1:0]         ld_word;
  logic                    ld_sat;
  logic [3*PW-1:0]         src_word;
  logic [NCW-1:0]          k_inc;
  logic [HNW-1:0]          num_mag, bl_rnd;
  logic signed [CW-1:0]    r_s, b_val, q_s, ax_val, c_ext;
  logic [DENW:0]           rs;
  logic                    ge;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  assign cnt_eff = (32'(vertex_count_q) >= 32'(MAX_VERTICES)) ? VCW'(MAX_VERTICES)
                                                              : VCW'(vertex_count_q);
  assign vi_ok  = 32'(vi_q) < 32'(cnt_eff);
  assign ni_ok  = 32'(ni_q) < 32'(cnt_eff);
  assign vi_a   = VAW'(vi_q);
  assign v_a    = v_q[VAW-1:0];
  assign v_done = (v_q == cnt_eff);
  // A stored neighbour past the memory size reads vertex zero.
  assign nb_ok  = 32'(t_rd_q) < 32'(MAX_VERTICES);
  assign nb_a   = nb_ok ? VAW'(t_rd_q) : '0;

  assign alpha_e  = (alpha_q > ONE_Q16) ? ONE_Q16 : alpha_q;
  assign beta_e   = (beta_q > ONE_Q16) ? ONE_Q16 : beta_q;
  assign om_alpha = ONE_Q16 - alpha_e;
  assign om_beta  = ONE_Q16 - beta_e;

  assign o_ax = $signed(o_rd_q[axis_q*PW +: PW]);
  assign c_ax = $signed(c_rd_q[axis_q*PW +: PW]);
  assign p_ax = $signed(p_rd_q[axis_q*PW +: PW]);
  assign d_ax = $signed(d_rd_q[axis_q*PW +: PW]);

  assign sw_issue = (sw_q != VCW'(MAX_VERTICES));
  assign sw_done  = !sw_issue && !sw_pend_q;
  assign src_word = hc_ph_q ? d_rd_q : p_rd_q;
  assign k_inc    = k_q + 1'b1;

  always_comb begin
    ld_sat = 1'b0;
    for (int a = 0; a < 3; a++) begin
      ld_ext[a] = pos_q[a];
      ld_word[a*PW +: PW] = clamp_pos(ld_ext[a]);
      if (!fits_pos(ld_ext[a])) ld_sat = 1'b1;
    end
  end

  // Rounded blend, ties away from zero, then the difference b.
  always_comb begin
    num_mag = num_q[HNW-1] ? HNW'(-num_q) : HNW'(num_q);
    bl_rnd  = (num_mag + HNW'(32768)) >> 16;
    r_s     = num_q[HNW-1] ? -$signed(bl_rnd[CW-1:0]) : $signed(bl_rnd[CW-1:0]);
    c_ext   = c_ax;
    b_val   = c_ext - r_s;
    q_s     = dneg_q ? -$signed(dvq_q[CW-1:0]) : $signed(dvq_q[CW-1:0]);
    ax_val  = hc_ph_q ? (c_ext - q_s) : q_s;
    rs      = {rem_q, dvq_q[HNW-1]};
    ge      = (rs >= {1'b0, den_q});
  end

  always_comb begin
    state_d   = state_q;
    sw_d      = sw_q;
    sw_pend_d = 1'b0;
    sw_addr_d = sw_q[VAW-1:0];
    v_d       = v_q;
    k_d       = k_q;
    axis_d    = axis_q;
    pc_d      = pc_q;
    hc_ph_d   = hc_ph_q;
    dcnt_d    = dcnt_q;
    rv_d      = 1'b0;
    sat_d     = sat_q;
    cmd_d     = cmd_q;
    vi_d      = vi_q;
    ni_d      = ni_q;
    for (int a = 0; a < 3; a++) begin
      pos_d[a] = pos_q[a];
      acc_d[a] = acc_q[a];
    end
    base_d = base_q;
    c_d    = c_q;
    res_d  = res_q;
    p1_d   = p1_q;
    p2_d   = p2_q;
    num_d  = num_q;
    den_d  = den_q;
    dvq_d  = dvq_q;
    rem_d  = rem_q;
    dneg_d = dneg_q;
    echo_d = echo_q;
    ox_d   = ox_q;
    oy_d   = oy_q;
    oz_d   = oz_q;
    st_d   = st_q;

    o_re = 1'b0; o_we = 1'b0; o_ra = '0; o_wa = '0; o_wd = '0;
    c_re = 1'b0; c_we = 1'b0; c_ra = '0; c_wa = '0; c_wd = '0;
    p_re = 1'b0; p_we = 1'b0; p_ra = '0; p_wa = '0; p_wd = '0;
    d_re = 1'b0; d_we = 1'b0; d_ra = '0; d_wa = '0; d_wd = '0;
    t_re = 1'b0; t_we = 1'b0; t_ra = '0; t_wa = '0; t_wd = '0;
    n_re = 1'b0; n_we = 1'b0; n_ra = '0; n_wa = '0; n_wd = '0;

    unique case (state_q)
      S_CLEAR: begin
        n_we = sw_issue;
        n_wa = sw_q[VAW-1:0];
        if (sw_issue) begin
          sw_d = sw_q + 1'b1;
        end else begin
          sw_d    = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_d    = command_i;
          vi_d     = vertex_index_i;
          ni_d     = neighbour_index_i;
          pos_d[0] = pos_x_i;
          pos_d[1] = pos_y_i;
          pos_d[2] = pos_z_i;
          sat_d    = 1'b0;
          unique case (cmd_e'(command_i))
            CMD_LOAD:   state_d = S_LOAD;
            CMD_APPEND: state_d = S_APP_RD;
            CMD_READ:   state_d = S_RD_ISS;
            CMD_RUN: begin
              sw_d    = '0;
              pc_d    = '0;
              state_d = S_CP_OCP;
            end
          endcase
        end
      end
      S_LOAD: begin
        o_we = vi_ok; o_wa = vi_a; o_wd = ld_word;
        c_we = vi_ok; c_wa = vi_a; c_wd = ld_word;
        rv_d = 1'b1; echo_d = vi_q; ox_d = '0; oy_d = '0; oz_d = '0;
        st_d = !vi_ok ? STAT_RANGE : (ld_sat ? STAT_SAT : STAT_OK);
        state_d = S_IDLE;
      end
      S_APP_RD: begin
        n_re = 1'b1; n_ra = vi_a;
        state_d = S_APP_WR;
      end
      S_APP_WR: begin
        rv_d = 1'b1; echo_d = vi_q; ox_d = '0; oy_d = '0; oz_d = '0;
        if (!(vi_ok && ni_ok)) begin
          st_d = STAT_RANGE;
        end else if (n_rd_q >= NCW'(MAX_NEIGHBOURS)) begin
          st_d = STAT_FULL;
        end else begin
          st_d = STAT_OK;
          t_we = 1'b1;
          t_wa = TAW'(32'(vi_a) * MAX_NEIGHBOURS) + TAW'(n_rd_q);
          t_wd = ni_q;
          n_we = 1'b1; n_wa = vi_a; n_wd = n_rd_q + 1'b1;
        end
        state_d = S_IDLE;
      end
      S_RD_ISS: begin
        c_re = 1'b1; c_ra = vi_a;
        state_d = S_RD_OUT;
      end
      S_RD_OUT: begin
        rv_d = 1'b1; echo_d = vi_q;
        if (vi_ok) begin
          ox_d = $signed(c_rd_q[0 +: PW]);
          oy_d = $signed(c_rd_q[PW +: PW]);
          oz_d = $signed(c_rd_q[2*PW +: PW]);
          st_d = STAT_OK;
        end else begin
          ox_d = '0; oy_d = '0; oz_d = '0;
          st_d = STAT_RANGE;
        end
        state_d = S_IDLE;
      end
      // Whole-memory copies: read one entry a cycle, write it to the target memories in the next cycle.
      S_CP_OCP, S_CP_CP, S_CP_CD: begin
        sw_pend_d = sw_issue;
        if (sw_issue) sw_d = sw_q + 1'b1;
        if (state_q == S_CP_OCP) begin
          o_re = sw_issue; o_ra = sw_q[VAW-1:0];
          c_we = sw_pend_q; c_wa = sw_addr_q; c_wd = o_rd_q;
          p_we = sw_pend_q; p_wa = sw_addr_q; p_wd = o_rd_q;
        end else begin
          c_re = sw_issue; c_ra = sw_q[VAW-1:0];
          if (state_q == S_CP_CP) begin
            p_we = sw_pend_q; p_wa = sw_addr_q; p_wd = c_rd_q;
          end else begin
            d_we = sw_pend_q; d_wa = sw_addr_q; d_wd = c_rd_q;
          end
        end
        if (sw_done) begin
          sw_d   = '0;
          v_d    = '0;
          base_d = '0;
          priority case (state_q)
            S_CP_OCP: state_d = S_PASS_CHK;
            S_CP_CP: begin
              hc_ph_d = 1'b0;
              state_d = S_V_START;
            end
            default:  state_d = S_B_START;
          endcase
        end
      end
      S_PASS_CHK: begin
        if (pc_q == pass_count_q) begin
          state_d = hc_en_q ? S_CP_CD : S_FIN;
        end else begin
          pc_d    = pc_q + 1'b1;
          state_d = S_CP_CP;
        end
      end
      S_V_START: begin
        if (v_done) begin
          state_d = hc_ph_q ? S_FIN : S_PASS_CHK;
        end else begin
          n_re = 1'b1; n_ra = v_a;
          state_d = S_V_CHK;
        end
      end
      S_V_CHK: begin
        c_d = n_rd_q;
        if (n_rd_q == '0) begin
          v_d     = v_q + 1'b1;
          base_d  = base_q + TAW'(MAX_NEIGHBOURS);
          state_d = S_V_START;
        end else begin
          for (int a = 0; a < 3; a++) acc_d[a] = '0;
          k_d     = '0;
          state_d = S_T_RD;
        end
      end
      S_T_RD: begin
        t_re = 1'b1; t_ra = base_q + TAW'(k_q);
        state_d = S_N_RD;
      end
      S_N_RD: begin
        p_re = !hc_ph_q; p_ra = nb_a;
        d_re = hc_ph_q;  d_ra = nb_a;
        state_d = S_ACC;
      end
      S_ACC: begin
        for (int a = 0; a < 3; a++) begin
          acc_d[a] = acc_q[a] + $signed(src_word[a*PW +: PW]);
        end
        k_d = k_inc;
        if (k_inc == c_q) begin
          axis_d  = '0;
          state_d = hc_ph_q ? S_SELF_RD : S_AX_SET;
        end else begin
          state_d = S_T_RD;
        end
      end
      S_SELF_RD: begin
        d_re = 1'b1; d_ra = v_a;
        c_re = 1'b1; c_ra = v_a;
        state_d = S_AX_SET;
      end
      S_AX_SET: begin
        if (hc_ph_q) begin
          p1_d    = $signed({1'b0, beta_e}) * d_ax;
          p2_d    = $signed({1'b0, om_beta}) * acc_q[axis_q];
          den_d   = {c_q, 16'b0};
          state_d = S_HM2;
        end else begin
          num_d   = acc_q[axis_q];
          den_d   = DENW'(c_q);
          state_d = S_DIV_GO;
        end
      end
      S_HM2: begin
        num_d   = p1_q * $signed({1'b0, c_q});
        state_d = S_HM3;
      end
      S_HM3: begin
        num_d   = num_q + p2_q;
        state_d = S_DIV_GO;
      end
      S_DIV_GO: begin
        dvq_d   = num_mag + HNW'(den_q >> 1);
        dneg_d  = num_q[HNW-1];
        rem_d   = '0;
        dcnt_d  = '0;
        state_d = S_DIV_RUN;
      end
      // One quotient bit a cycle, restoring.
      S_DIV_RUN: begin
        rem_d  = ge ? DENW'(rs - {1'b0, den_q}) : rs[DENW-1:0];
        dvq_d  = {dvq_q[HNW-2:0], ge};
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DCW'(HNW - 1)) state_d = S_AX_END;
      end
      S_AX_END: begin
        res_d[axis_q*PW +: PW] = clamp_pos(ax_val);
        if (!fits_pos(ax_val)) sat_d = 1'b1;
        if (axis_q == 2'd2) begin
          state_d = S_V_WR;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = S_AX_SET;
        end
      end
      S_V_WR: begin
        c_we = 1'b1; c_wa = v_a; c_wd = res_q;
        v_d     = v_q + 1'b1;
        base_d  = base_q + TAW'(MAX_NEIGHBOURS);
        state_d = S_V_START;
      end
      S_B_START: begin
        if (v_done) begin
          v_d     = '0;
          base_d  = '0;
          hc_ph_d = 1'b1;
          state_d = S_V_START;
        end else begin
          o_re = 1'b1; o_ra = v_a;
          p_re = 1'b1; p_ra = v_a;
          c_re = 1'b1; c_ra = v_a;
          axis_d  = '0;
          state_d = S_BM1;
        end
      end
      S_BM1: begin
        p1_d    = $signed({1'b0, alpha_e}) * o_ax;
        p2_d    = $signed({1'b0, om_alpha}) * p_ax;
        state_d = S_BM2;
      end
      S_BM2: begin
        num_d   = p1_q + p2_q;
        state_d = S_BM3;
      end
      S_BM3: begin
        res_d[axis_q*PW +: PW] = clamp_pos(b_val);
        if (!fits_pos(b_val)) sat_d = 1'b1;
        if (axis_q == 2'd2) begin
          state_d = S_B_WR;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = S_BM1;
        end
      end
      S_B_WR: begin
        d_we = 1'b1; d_wa = v_a; d_wd = res_q;
        v_d     = v_q + 1'b1;
        state_d = S_B_START;
      end
      S_FIN: begin
        rv_d = 1'b1; echo_d = '0; ox_d = '0; oy_d = '0; oz_d = '0;
        st_d = sat_q ? STAT_SAT : STAT_OK;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      sw_q           <= '0;
      sw_pend_q      <= 1'b0;
      v_q            <= '0;
      k_q            <= '0;
      axis_q         <= '0;
      pc_q           <= '0;
      hc_ph_q        <= 1'b0;
      dcnt_q         <= '0;
      rv_q           <= 1'b0;
      sat_q          <= 1'b0;
      vertex_count_q <= 11'd1024;
      pass_count_q   <= 8'd1;
      hc_en_q        <= 1'b0;
      alpha_q        <= 17'd0;
      beta_q         <= 17'd32768;
    end else begin
      state_q   <= state_d;
      sw_q      <= sw_d;
      sw_pend_q <= sw_pend_d;
      v_q       <= v_d;
      k_q       <= k_d;
      axis_q    <= axis_d;
      pc_q      <= pc_d;
      hc_ph_q   <= hc_ph_d;
      dcnt_q    <= dcnt_d;
      rv_q      <= rv_d;
      sat_q     <= sat_d;
      if (cfg_we_i) begin
        unique case (cfg_e'(cfg_index_i))
          CFG_VCOUNT: vertex_count_q <= cfg_data_i[10:0];
          CFG_PASSES: pass_count_q   <= cfg_data_i[7:0];
          CFG_HC:     hc_en_q        <= cfg_data_i[0];
          CFG_ALPHA:  alpha_q        <= cfg_data_i;
          CFG_BETA:   beta_q         <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    vi_q      <= vi_d;
    ni_q      <= ni_d;
    for (int a = 0; a < 3; a++) begin
      pos_q[a] <= pos_d[a];
      acc_q[a] <= acc_d[a];
    end
    sw_addr_q <= sw_addr_d;
    base_q    <= base_d;
    c_q       <= c_d;
    res_q     <= res_d;
    p1_q      <= p1_d;
    p2_q      <= p2_d;
    num_q     <= num_d;
    den_q     <= den_d;
    dvq_q     <= dvq_d;
    rem_q     <= rem_d;
    dneg_q    <= dneg_d;
    echo_q    <= echo_d;
    ox_q      <= ox_d;
    oy_q      <= oy_d;
    oz_q      <= oz_d;
    st_q      <= st_d;
  end

  assign result_valid_o = rv_q;
  assign echo_index_o   = echo_q;
  assign out_x_o        = ox_q;
  assign out_y_o        = oy_q;
  assign out_z_o        = oz_q;
  assign status_o       = st_q;

  // Every command makes the sequencer busy in the cycle after its transfer.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("command transfer did not make the block busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for two cycles");

  a_sat_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (cmd_q == CMD_APPEND || cmd_q == CMD_READ)
      |-> status_o != STAT_SAT)
    else $error("saturation reported for append or read");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV_RUN |-> dcnt_q < DCW'(HNW))
    else $error("divider ran past its last step");

endmodule
`default_nettype wire
